[rtl/spq_pkg.sv]
// Package for the sorted priority queue: operation and status codes,
// the entry and per-cycle operation types shared by the cell row and top level.
// No dependencies.
package spq_pkg;

  localparam int KEY_W = 16;
  localparam int TAG_W = 16;
  localparam int OCC_W = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  // Operation codes carried in the cmd field
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One slot of the sorted row
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Operation broadcast to every cell in the accepted cycle
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } op_t;

endpackage

[rtl/sorted_priority_queue.sv]
// Sorted priority queue: input stream of insert/remove commands, one result
// transaction per command. Depends on spq_pkg and spq_cell.
//
// Usage:
//   in_*  carries a command: cmd (insert or remove), key and tag.
//   out_* returns one transaction per command: status, head_valid,
//   head_key, head_tag and occupancy, all taken after the command.
//   Entries are kept in a row of CAPACITY cells sorted by ascending key;
//   equal keys leave in arrival order. Every cell compares its key with the
//   new key in parallel, so an insert or remove updates the whole row at once.
// The result is registered and appears in the cycle after the command is accepted.
// Throughput: one command per cycle while out_tready is high, set by the cell
//   update and the one output register.
// Reset: rst_n low empties the queue and drops any pending result.
// Stall: while a result waits and out_tready is low, in_tready is low;
//   the queue and the pending result hold until the result is taken.
// An insert into a full queue is dropped with status full; a remove on an
// empty queue reports status empty and leaves the queue unchanged.
module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [0] cmd, [16:1] key, [32:17] tag, [39:33] zero
  input  logic [spq_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [1:0] status, [2] head_valid, [18:3] head_key, [34:19] head_tag,
  // [39:35] occupancy
  output logic [spq_pkg::OUT_DATA_W-1:0] out_tdata
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic             in_cmd;
  logic [KEY_W-1:0] in_key;
  logic [TAG_W-1:0] in_tag;
  logic             accept;
  logic             full;
  logic             empty;
  op_t              op;
  status_t          status_nxt;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic             out_valid_r;
  status_t          status_r;
  logic             head_valid_r;
  logic [KEY_W-1:0] head_key_r;
  logic [TAG_W-1:0] head_tag_r;
  logic [OCC_W-1:0] occ_r;

  entry_t cur  [CAPACITY];
  entry_t nxt  [CAPACITY];
  logic   keep [CAPACITY];

  // Unpack the command
  assign in_cmd = in_tdata[0];
  assign in_key = in_tdata[KEY_W:1];
  assign in_tag = in_tdata[KEY_W+TAG_W:KEY_W+1];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);

  // Build the operation broadcast to the cells
  always_comb begin
    op.ins     = accept && (in_cmd == CMD_INSERT) && !full;
    op.rem     = accept && (in_cmd == CMD_REMOVE) && !empty;
    op.key     = in_key;
    op.tag     = in_tag;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    if (in_cmd == CMD_INSERT) begin
      if (full) status_nxt = ST_FULL;
    end else begin
      if (empty) status_nxt = ST_EMPTY;
    end
    if (op.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (op.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Row of cells, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_ent;
    entry_t next_ent;
    logic   prev_keep;

    if (i == 0) begin : g_first
      assign prev_ent  = '0;
      assign prev_keep = 1'b1;
    end else begin : g_mid
      assign prev_ent  = cur[i-1];
      assign prev_keep = keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = cur[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op_i       (op),
      .prev_i     (prev_ent),
      .prev_keep_i(prev_keep),
      .next_i     (next_ent),
      .keep_o     (keep[i]),
      .cur_o      (cur[i]),
      .nxt_o      (nxt[i])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the result transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      head_valid_r <= nxt[0].valid;
      head_key_r   <= nxt[0].valid ? nxt[0].key : '0;
      head_tag_r   <= nxt[0].valid ? nxt[0].tag : '0;
      occ_r        <= OCC_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {occ_r, head_tag_r, head_key_r, head_valid_r, status_r};

endmodule

[rtl/spq_cell.sv]
// One cell of the sorted row: holds a single entry and decides each cycle
// whether to hold, take the new entry, or take a neighbour's entry.
// Depends on spq_pkg.
module spq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  spq_pkg::op_t   op_i,
  input  spq_pkg::entry_t prev_i,
  input  logic           prev_keep_i,
  input  spq_pkg::entry_t next_i,
  output logic           keep_o,
  output spq_pkg::entry_t cur_o,
  output spq_pkg::entry_t nxt_o
);
  import spq_pkg::*;

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  logic [TAG_W-1:0] tag_r;
  entry_t           ent_nxt;

  assign cur_o  = '{valid: valid_r, key: key_r, tag: tag_r};
  // Entry stays put on insert when its key is not above the new key
  assign keep_o = valid_r && (key_r <= op_i.key);
  assign nxt_o  = ent_nxt;

  // Choose the next content of this slot
  always_comb begin
    ent_nxt = cur_o;
    if (op_i.ins) begin
      if (keep_o) begin
        ent_nxt = cur_o;
      end else if (prev_keep_i) begin
        ent_nxt = '{valid: 1'b1, key: op_i.key, tag: op_i.tag};
      end else begin
        ent_nxt = prev_i;
      end
    end else if (op_i.rem) begin
      ent_nxt = next_i;
    end
  end

  // Register the valid flag, cleared under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ent_nxt.valid;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    key_r <= ent_nxt.key;
    tag_r <= ent_nxt.tag;
  end

endmodule
